### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the RTL of the lookup core.
// ----------------------------------------------------------------------------
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SALC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SALC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### sv/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Geometry, types and codes of the set-associative LRU cache lookup core.
// ----------------------------------------------------------------------------
package salc_pkg;

  // SET_COUNT is a power of two: the set is the low address bits.
  localparam int unsigned SET_COUNT    = 2048;
  localparam int unsigned WAYS         = 16;
  localparam int unsigned ADDRESS_BITS = 42;

  localparam int unsigned ADDR_W   = 42;
  localparam int unsigned COUNT_W  = 48;
  localparam int unsigned SET_BITS = $clog2(SET_COUNT);
  localparam int unsigned SET_W    = (SET_COUNT > 1) ? SET_BITS : 1;
  localparam int unsigned TAG_W    = ADDRESS_BITS - SET_BITS;
  localparam int unsigned RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [RANK_W-1:0]  LRU_RANK  = RANK_W'(WAYS - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SET_W-1:0]   SET_MASK  = SET_W'(SET_COUNT - 1);
  localparam logic [SET_W-1:0]   LAST_SET  = SET_W'(SET_COUNT - 1);

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  typedef struct packed {
    logic hit;
    logic evicted;
    logic filled;
  } upd_res_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

endpackage

### sv/salc_ram.sv
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module salc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/salc_update.sv
// ----------------------------------------------------------------------------
// salc_update
// Tag match, way choice and rank update of one set's row.
// ----------------------------------------------------------------------------
module salc_update (
  input  salc_pkg::row_t              row_i,
  input  logic [salc_pkg::TAG_W-1:0]  tag_i,
  output salc_pkg::row_t              row_o,
  output salc_pkg::upd_res_t          res_o
);

  logic [salc_pkg::WAYS-1:0]   hit_vec;
  logic [salc_pkg::WAYS-1:0]   free_vec;
  logic [salc_pkg::WAYS-1:0]   lru_vec;
  logic [salc_pkg::RANK_W-1:0] hit_way;
  logic [salc_pkg::RANK_W-1:0] free_way;
  logic [salc_pkg::RANK_W-1:0] lru_way;
  logic [salc_pkg::RANK_W-1:0] way;
  logic [salc_pkg::RANK_W-1:0] limit;
  logic                        hit;
  logic                        have_free;
  logic                        inc;

  // Per-way match vectors
  always_comb begin
    for (int w = 0; w < salc_pkg::WAYS; w++) begin
      hit_vec[w]  = row_i[w].valid && (row_i[w].tag == tag_i);
      free_vec[w] = !row_i[w].valid;
      // A full set holds every rank once: the oldest has the top rank
      lru_vec[w]  = row_i[w].rank == salc_pkg::LRU_RANK;
    end
  end

  // Lowest-numbered way of each vector
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    lru_way  = '0;
    for (int w = salc_pkg::WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = salc_pkg::RANK_W'(w);
      end
      if (free_vec[w]) begin
        free_way = salc_pkg::RANK_W'(w);
      end
      if (lru_vec[w]) begin
        lru_way = salc_pkg::RANK_W'(w);
      end
    end
  end

  assign hit       = |hit_vec;
  assign have_free = |free_vec;

  always_comb begin
    if (hit) begin
      way   = hit_way;
      limit = row_i[hit_way].rank;
    end else if (have_free) begin
      way   = free_way;
      limit = salc_pkg::LRU_RANK;
    end else begin
      way   = lru_way;
      limit = salc_pkg::LRU_RANK;
    end
  end

  // Age every valid way younger than the limit; a fill ages all of them
  always_comb begin
    inc = 1'b0;
    for (int w = 0; w < salc_pkg::WAYS; w++) begin
      inc      = row_i[w].valid && ((!hit && have_free) || (row_i[w].rank < limit));
      row_o[w] = row_i[w];
      row_o[w].rank = row_i[w].rank + salc_pkg::RANK_W'(inc);
      if (salc_pkg::RANK_W'(w) == way) begin
        row_o[w].valid = 1'b1;
        row_o[w].tag   = tag_i;
        row_o[w].rank  = '0;
      end
    end
  end

  assign res_o.hit     = hit;
  assign res_o.filled  = !hit && have_free;
  assign res_o.evicted = !hit && !have_free;

endmodule

### sv/set_assoc_lru_cache_lookup_core.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_core
// Set-associative cache tag lookup with true LRU replacement and counters.
// ----------------------------------------------------------------------------
// Each accepted block address is looked up in its set (low address bits);
// a hit makes the way most recent, a miss fills the lowest free way or
// replaces the least recently used one. The result carries hit and evicted
// flags plus saturating 48-bit hit, miss, fill and evict totals. The whole
// set (valid, tag and rank of every way) lives in one row of a single RAM,
// so an item is handled in two steps: its row is read, then updated and
// written back. A new address is taken only once the last one has left
// the lookup, which stalls while the result register is full. The result
// is registered as the lookup ends and held until taken. After reset the
// core clears all SET_COUNT (2048) rows, one row a cycle, holding in_ready_o low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module set_assoc_lru_cache_lookup_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [salc_pkg::ADDR_W-1:0]   block_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic                          evicted_o,
  output logic [salc_pkg::COUNT_W-1:0]  hit_count_o,
  output logic [salc_pkg::COUNT_W-1:0]  miss_count_o,
  output logic [salc_pkg::COUNT_W-1:0]  fill_count_o,
  output logic [salc_pkg::COUNT_W-1:0]  evict_count_o
);

  salc_pkg::state_e state_q, state_d;

  logic [salc_pkg::SET_W-1:0]   clr_idx_q, clr_idx_d;
  logic [salc_pkg::SET_W-1:0]   set_q;
  logic [salc_pkg::SET_W-1:0]   in_set;
  logic [salc_pkg::TAG_W-1:0]   tag_q;
  logic                         out_valid_q, out_valid_d;
  logic                         hit_q;
  logic                         evicted_q;
  logic [salc_pkg::COUNT_W-1:0] hit_cnt_q, miss_cnt_q, fill_cnt_q, evict_cnt_q;

  logic                         in_fire;
  logic                         out_free;
  logic                         lookup_fire;
  logic                         ram_we;
  logic [salc_pkg::SET_W-1:0]   ram_waddr;
  logic [salc_pkg::ROW_W-1:0]   ram_wdata;
  logic [salc_pkg::ROW_W-1:0]   ram_rdata;
  salc_pkg::row_t               row_new;
  salc_pkg::upd_res_t           upd;

  // Set is the low address bits, tag the bits above it up to ADDRESS_BITS
  assign in_set   = block_address_i[salc_pkg::SET_W-1:0] & salc_pkg::SET_MASK;
  assign in_fire  = in_valid_i && in_ready_o;
  // The result register frees up in the same cycle it is taken
  assign out_free = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    case (state_q)
      salc_pkg::ST_CLEAR: begin
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == salc_pkg::LAST_SET) begin
          state_d = salc_pkg::ST_IDLE;
        end
      end
      salc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = salc_pkg::ST_LOOKUP;
        end
      end
      salc_pkg::ST_LOOKUP: begin
        // Hold the row read until the result register can take the outcome
        if (out_free) begin
          state_d = salc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = salc_pkg::ST_CLEAR;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Outputs of the sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    in_ready_o  = 1'b0;
    lookup_fire = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = set_q;
    ram_wdata   = row_new;
    case (state_q)
      salc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        ram_wdata = '0;
      end
      salc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      salc_pkg::ST_LOOKUP: begin
        lookup_fire = out_free;
        ram_we      = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Result valid: set on update, drop once transferred
  always_comb begin
    out_valid_d = out_valid_q;
    if (lookup_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= salc_pkg::ST_CLEAR;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      fill_cnt_q  <= '0;
      evict_cnt_q <= '0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
      if (lookup_fire) begin
        if (upd.hit && (hit_cnt_q != salc_pkg::COUNT_MAX)) begin
          hit_cnt_q <= hit_cnt_q + 1'b1;
        end
        if (!upd.hit && (miss_cnt_q != salc_pkg::COUNT_MAX)) begin
          miss_cnt_q <= miss_cnt_q + 1'b1;
        end
        if (upd.filled && (fill_cnt_q != salc_pkg::COUNT_MAX)) begin
          fill_cnt_q <= fill_cnt_q + 1'b1;
        end
        if (upd.evicted && (evict_cnt_q != salc_pkg::COUNT_MAX)) begin
          evict_cnt_q <= evict_cnt_q + 1'b1;
        end
      end
    end
  end

  // Address capture and result flags carry no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      set_q <= in_set;
      tag_q <= block_address_i[salc_pkg::ADDRESS_BITS-1:salc_pkg::SET_BITS];
    end
    if (lookup_fire) begin
      hit_q     <= upd.hit;
      evicted_q <= upd.evicted;
    end
  end

  // ---------------------------------------------------------------------
  // Set store: one row per set, read on the address transfer, written
  // back in the lookup cycle. Only one item is in flight, so a read never
  // meets a pending write to the same row.
  // ---------------------------------------------------------------------
  salc_ram #(
    .WIDTH (salc_pkg::ROW_W),
    .DEPTH (salc_pkg::SET_COUNT)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (in_set),
    .rdata_o (ram_rdata)
  );

  salc_update u_update (
    .row_i (salc_pkg::row_t'(ram_rdata)),
    .tag_i (tag_q),
    .row_o (row_new),
    .res_o (upd)
  );

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign evicted_o     = evicted_q;
  assign hit_count_o   = hit_cnt_q;
  assign miss_count_o  = miss_cnt_q;
  assign fill_count_o  = fill_cnt_q;
  assign evict_count_o = evict_cnt_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `SALC_ASSERT(a_accept_to_lookup,
               in_fire |=> (state_q == salc_pkg::ST_LOOKUP),
               "accepted address did not enter lookup")
  `SALC_ASSERT_NEVER(a_no_write_idle,
                     ram_we && (state_q == salc_pkg::ST_IDLE),
                     "set store written while idle")
  `SALC_ASSERT_NEVER(a_hit_no_evict,
                     out_valid_q && hit_q && evicted_q,
                     "hit reported together with eviction")
  `SALC_ASSERT(a_miss_count_step,
               (lookup_fire && !upd.hit && (miss_cnt_q != salc_pkg::COUNT_MAX))
                 |=> (miss_cnt_q == $past(miss_cnt_q) + 1'b1),
               "miss count did not advance on a miss")

endmodule

### test/tb_set_assoc_lru_cache_lookup_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_lookup_core
// Self-checking testbench for the set-associative LRU cache lookup core.
// ----------------------------------------------------------------------------
// Keeps its own copy of the tag store (valid, tag and recency rank per way)
// and of the four running totals. Each accepted block address is looked up
// in that copy, and the outcome is queued. Every result leaving the core is
// checked field by field against the oldest queued outcome. The stimulus is
// a directed part at the address extremes, then a filled set driven through
// hits and evictions, then random traffic on a few hot sets and scattered
// random addresses. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_lookup_core;

  localparam int unsigned WATCHDOG_LIMIT = 10000;  // longer than the clear pass over all sets
  localparam int unsigned IDLE_PERCENT   = 23;
  localparam int unsigned HOT_SETS       = 4;
  localparam int unsigned HOT_TAGS       = 20;     // more than WAYS: forces evictions
  localparam int unsigned MAX_REPORTS    = 40;

  typedef logic [salc_pkg::ADDR_W-1:0]  block_addr_t;
  typedef logic [salc_pkg::TAG_W-1:0]   tag_t;
  typedef logic [salc_pkg::COUNT_W-1:0] count_t;

  typedef struct packed {
    logic   hit;
    logic   evicted;
    count_t hits;
    count_t misses;
    count_t fills;
    count_t evicts;
  } lookup_result_t;

  // Core ports; every input has a known value from time zero.
  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  block_addr_t block_address = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic        hit;
  logic        evicted;
  count_t      hit_count;
  count_t      miss_count;
  count_t      fill_count;
  count_t      evict_count;

  // Shadow of the tag store and totals.
  bit                          cache_valid [salc_pkg::SET_COUNT][salc_pkg::WAYS];
  tag_t                        cache_tag   [salc_pkg::SET_COUNT][salc_pkg::WAYS];
  logic [salc_pkg::RANK_W-1:0] cache_rank  [salc_pkg::SET_COUNT][salc_pkg::WAYS];
  count_t hits_total   = '0;
  count_t misses_total = '0;
  count_t fills_total  = '0;
  count_t evicts_total = '0;

  lookup_result_t pending_lookups[$];

  int unsigned addresses_sent  = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;
  bit          back_to_back    = 1'b0;  // suppress gaps on both sides

  set_assoc_lru_cache_lookup_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .block_address_i (block_address),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .hit_o           (hit),
    .evicted_o       (evicted),
    .hit_count_o     (hit_count),
    .miss_count_o    (miss_count),
    .fill_count_o    (fill_count),
    .evict_count_o   (evict_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic count_t count_up(count_t value);
    return (value == salc_pkg::COUNT_MAX) ? value : value + 1'b1;
  endfunction

  // Make a way most recent: every valid way younger than the limit ages by one.
  function automatic void promote_way(int unsigned set_idx, int unsigned way,
                                      int unsigned limit);
    for (int unsigned w = 0; w < salc_pkg::WAYS; w++) begin
      if (cache_valid[set_idx][w] && int'(cache_rank[set_idx][w]) < limit) begin
        cache_rank[set_idx][w] = cache_rank[set_idx][w] + 1'b1;
      end
    end
    cache_rank[set_idx][way] = '0;
  endfunction

  function automatic lookup_result_t predict_lookup(block_addr_t addr);
    logic [63:0]    used_addr;
    int unsigned    set_idx;
    tag_t           tag;
    int unsigned    way;
    int unsigned    oldest;
    bit             found;
    bit             free_found;
    lookup_result_t res;
    used_addr  = 64'(addr) & ((64'd1 << salc_pkg::ADDRESS_BITS) - 64'd1);
    set_idx    = int'(used_addr % salc_pkg::SET_COUNT);
    tag        = salc_pkg::TAG_W'(used_addr / salc_pkg::SET_COUNT);
    way        = 0;
    found      = 1'b0;
    free_found = 1'b0;
    res        = '0;
    for (int unsigned w = 0; w < salc_pkg::WAYS; w++) begin
      if (!found && cache_valid[set_idx][w] && cache_tag[set_idx][w] == tag) begin
        found = 1'b1;
        way   = w;
      end
    end
    if (found) begin
      promote_way(set_idx, way, 32'(cache_rank[set_idx][way]));
      hits_total = count_up(hits_total);
    end else begin
      misses_total = count_up(misses_total);
      for (int unsigned w = 0; w < salc_pkg::WAYS; w++) begin
        if (!free_found && !cache_valid[set_idx][w]) begin
          free_found = 1'b1;
          way        = w;
        end
      end
      if (free_found) begin
        // Fill the lowest free way; all valid ways age by one.
        promote_way(set_idx, way, salc_pkg::WAYS + 1);
        cache_valid[set_idx][way] = 1'b1;
        cache_tag[set_idx][way]   = tag;
        cache_rank[set_idx][way]  = '0;
        fills_total = count_up(fills_total);
      end else begin
        // Replace the least recent way, lowest index on a tie.
        oldest = 0;
        way    = 0;
        for (int unsigned w = 0; w < salc_pkg::WAYS; w++) begin
          if (32'(cache_rank[set_idx][w]) > oldest) begin
            oldest = 32'(cache_rank[set_idx][w]);
            way    = w;
          end
        end
        res.evicted = 1'b1;
        promote_way(set_idx, way, oldest);
        cache_tag[set_idx][way] = tag;
        evicts_total = count_up(evicts_total);
      end
    end
    res.hit    = found;
    res.hits   = hits_total;
    res.misses = misses_total;
    res.fills  = fills_total;
    res.evicts = evicts_total;
    return res;
  endfunction

  function automatic block_addr_t make_address(tag_t tag, int unsigned set_idx);
    return (block_addr_t'(tag) << salc_pkg::SET_BITS) | block_addr_t'(set_idx);
  endfunction

  // --------------------------------------------------------------------------
  // Address side
  // --------------------------------------------------------------------------
  // Called at a rising edge; returns at the edge on which the transfer happens.
  // Valid is only lowered by a gap before an address or by drain_lookups.
  task automatic send_address(block_addr_t addr);
    while (!back_to_back && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    block_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_lookups.insert(pending_lookups.size(), predict_lookup(addr));
    addresses_sent++;
  endtask

  // Hold off new addresses until every queued outcome has been checked.
  task automatic drain_lookups();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= back_to_back || ($urandom_range(99) >= IDLE_PERCENT);
  end

  task automatic report_mismatch(string what, count_t got, count_t want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch on result %0d, %s: got %0h, expected %0h",
               results_checked, what, got, want);
    end
  endtask

  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        want = pending_lookups.pop_front();
        if (hit !== want.hit) begin
          report_mismatch("hit", salc_pkg::COUNT_W'(hit), salc_pkg::COUNT_W'(want.hit));
        end
        if (evicted !== want.evicted) begin
          report_mismatch("evicted", salc_pkg::COUNT_W'(evicted),
                          salc_pkg::COUNT_W'(want.evicted));
        end
        if (hit_count !== want.hits)     report_mismatch("hit_count", hit_count, want.hits);
        if (miss_count !== want.misses)  report_mismatch("miss_count", miss_count, want.misses);
        if (fill_count !== want.fills)   report_mismatch("fill_count", fill_count, want.fills);
        if (evict_count !== want.evicts) report_mismatch("evict_count", evict_count, want.evicts);
      end
      results_checked++;
    end
  end

  // Abort when neither channel has moved a transfer for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d lookups outstanding",
                 WATCHDOG_LIMIT, pending_lookups.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Lowest and highest address, a repeat for a hit, the last set with tag zero.
  task automatic test_extreme_addresses();
    send_address('0);
    send_address({salc_pkg::ADDR_W{1'b1}});
    send_address('0);
    send_address(make_address('0, salc_pkg::SET_COUNT - 1));
  endtask

  // Fill one set completely, hit its oldest line, then replace twice.
  task automatic test_fill_then_evict();
    for (int unsigned t = 1; t <= salc_pkg::WAYS; t++) begin
      send_address(make_address(salc_pkg::TAG_W'(t), 5));
    end
    send_address(make_address(salc_pkg::TAG_W'(1), 5));  // hit on way 0, now most recent
    // Evicts the line of tag 2
    send_address(make_address(salc_pkg::TAG_W'(salc_pkg::WAYS + 1), 5));
    send_address(make_address(salc_pkg::TAG_W'(2), 5));  // miss again, evicts tag 3
  endtask

  // Heavy traffic on a few sets with a tag pool just larger than the ways,
  // so hits, fills and evictions all keep happening. Some noise mixed in.
  task automatic test_hot_set_traffic(int unsigned count);
    int unsigned hot_set [HOT_SETS];
    tag_t        hot_tag [HOT_SETS][HOT_TAGS];
    int unsigned pick;
    hot_set[0] = 0;
    hot_set[1] = salc_pkg::SET_COUNT - 1;
    hot_set[2] = $urandom_range(salc_pkg::SET_COUNT - 2, 1);
    hot_set[3] = $urandom_range(salc_pkg::SET_COUNT - 2, 1);
    for (int unsigned s = 0; s < HOT_SETS; s++) begin
      hot_tag[s][0] = '0;
      hot_tag[s][1] = '1;
      for (int unsigned t = 2; t < HOT_TAGS; t++) begin
        hot_tag[s][t] = salc_pkg::TAG_W'($urandom());
      end
    end
    for (int unsigned n = 0; n < count; n++) begin
      // Run a stretch with no gaps on either side, and drain once midway.
      back_to_back = (n >= count / 3) && (n < count / 3 + 200);
      if (n == count / 2) drain_lookups();
      if ($urandom_range(99) < 85) begin
        pick = $urandom_range(HOT_SETS - 1);
        send_address(make_address(hot_tag[pick][$urandom_range(HOT_TAGS - 1)],
                                  hot_set[pick]));
      end else begin
        send_address(block_addr_t'({$urandom(), $urandom()}));
      end
    end
    back_to_back = 1'b0;
  endtask

  // Addresses spread over the whole range, with recent ones replayed for hits.
  task automatic test_scattered_addresses(int unsigned count);
    block_addr_t recent[$];
    block_addr_t addr;
    for (int unsigned n = 0; n < count; n++) begin
      if (recent.size() != 0 && $urandom_range(99) < 30) begin
        addr = recent[$urandom_range(recent.size() - 1)];
      end else begin
        addr = block_addr_t'({$urandom(), $urandom()});
      end
      recent.insert(recent.size(), addr);
      if (recent.size() > 16) void'(recent.pop_front());
      send_address(addr);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extreme_addresses();
    test_fill_then_evict();
    test_hot_set_traffic(950);
    test_scattered_addresses(280);

    // Let the last results out, then allow a few more cycles for strays.
    drain_lookups();
    repeat (8) @(posedge clk);

    $display("Sent %0d block addresses, checked %0d results, %0d mismatches.",
             addresses_sent, results_checked, mismatches);
    $display("Lookups gave %0d hits, %0d misses, %0d fills and %0d evictions.",
             hits_total, misses_total, fills_total, evicts_total);
    if (mismatches == 0 && pending_lookups.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
